// File: rtl/pscc_pkg.sv
// shared constants, status codes and controller/datapath bundles for the polygon classifier
// no dependencies
`default_nettype none
package pscc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;
    localparam int MIN_POLY     = 3;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int KEPT_W       = 9;
    localparam int STATUS_W     = 2;
    localparam int STEP_W       = 4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW_READ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW_KEPT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             accept;
        logic [IDX_W-1:0] rd_addr;
        logic             ld_en;
        logic [1:0]       ld_slot;
        logic             turn_en;
        logic [1:0]       turn_sel;
        logic             turn_conv;
        logic             eval;
    } t_cmd;

    typedef struct packed {
        logic             err;
        logic [CNT_W-1:0] n;
        logic             simple;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/pscc_dp.sv
// datapath: vertex store, dedup loader, point registers, pipelined turn unit, result flags
// depends on pscc_pkg
`default_nettype none
module pscc_dp import pscc_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                         i_last_vertex,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    output logic                              o_is_simple,
    output logic                              o_is_convex,
    output logic [KEPT_W-1:0]                 o_kept_count,
    output logic [STATUS_W-1:0]               o_status
);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int TURN_W = PROD_W + 1;
    localparam logic [1:0] ORI_ZERO = 2'd0;
    localparam logic [1:0] ORI_NEG  = 2'd1;
    localparam logic [1:0] ORI_POS  = 2'd2;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic signed [COORD_BITS-1:0] r_px [4];
    logic signed [COORD_BITS-1:0] r_py [4];

    logic [CNT_W-1:0]            r_kept, r_n;
    logic [1:0]                  r_raw;
    logic                        r_ovf;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_last_x, r_last_y;
    logic [STATUS_W-1:0]         r_status;
    logic                        r_simple, r_pos, r_neg;

    // loader next values
    logic                         is_new, store, ovf_nx, drop;
    logic [1:0]                   raw_nx;
    logic [CNT_W-1:0]             kept_nx, n_fin;
    logic signed [COORD_BITS-1:0] first_x_nx, first_y_nx, last_x_nx, last_y_nx;
    logic [STATUS_W-1:0]          status_nx;

    always_comb begin
        is_new     = (r_kept == '0) || (i_vertex_x != r_last_x) || (i_vertex_y != r_last_y);
        store      = is_new && (r_kept < CNT_W'(MAX_VERTICES));
        ovf_nx     = r_ovf || (is_new && !store);
        raw_nx     = (r_raw == 2'd3) ? r_raw : r_raw + 2'd1;
        kept_nx    = r_kept + CNT_W'(store);
        last_x_nx  = store ? i_vertex_x : r_last_x;
        last_y_nx  = store ? i_vertex_y : r_last_y;
        first_x_nx = (r_kept == '0) ? i_vertex_x : r_first_x;
        first_y_nx = (r_kept == '0) ? i_vertex_y : r_first_y;
        drop       = !ovf_nx && (kept_nx > CNT_W'(1)) &&
                     (first_x_nx == last_x_nx) && (first_y_nx == last_y_nx);
        n_fin      = kept_nx - CNT_W'(drop);
        if (raw_nx < 2'(MIN_POLY)) begin
            status_nx = ST_FEW_READ;
        end else if (ovf_nx) begin
            status_nx = ST_OVERFLOW;
        end else if (n_fin < CNT_W'(MIN_POLY)) begin
            status_nx = ST_FEW_KEPT;
        end else begin
            status_nx = ST_OK;
        end
    end

    // vertex store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store) begin
            mem_x[r_kept[IDX_W-1:0]] <= i_vertex_x;
            mem_y[r_kept[IDX_W-1:0]] <= i_vertex_y;
        end
        r_rd_x <= mem_x[i_cmd.rd_addr];
        r_rd_y <= mem_y[i_cmd.rd_addr];
        if (i_cmd.ld_en) begin
            r_px[i_cmd.ld_slot] <= r_rd_x;
            r_py[i_cmd.ld_slot] <= r_rd_y;
        end
    end

    // turn unit: differences, products, sign
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
    logic signed [DIFF_W-1:0]     r_ux, r_uy, r_vx, r_vy;
    logic signed [PROD_W-1:0]     r_m1, r_m2;
    logic signed [TURN_W-1:0]     turn_val;
    logic                         r_s1_v, r_s1_conv, r_s2_v, r_s2_conv;
    logic [1:0]                   r_s1_sel, r_s2_sel;
    logic [1:0]                   r_ori [4];
    logic [1:0]                   ori_now;

    always_comb begin
        case (i_cmd.turn_sel)
            2'd0, 2'd1: begin
                ax = r_px[0]; ay = r_py[0]; bx = r_px[1]; by = r_py[1];
            end
            default: begin
                ax = r_px[2]; ay = r_py[2]; bx = r_px[3]; by = r_py[3];
            end
        endcase
        case (i_cmd.turn_sel)
            2'd0:    begin cx = r_px[2]; cy = r_py[2]; end
            2'd1:    begin cx = r_px[3]; cy = r_py[3]; end
            2'd2:    begin cx = r_px[0]; cy = r_py[0]; end
            default: begin cx = r_px[1]; cy = r_py[1]; end
        endcase
        turn_val = TURN_W'(r_m1) - TURN_W'(r_m2);
        if (turn_val == '0) begin
            ori_now = ORI_ZERO;
        end else if (turn_val < 0) begin
            ori_now = ORI_NEG;
        end else begin
            ori_now = ORI_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ux <= DIFF_W'(bx) - DIFF_W'(ax);
        r_uy <= DIFF_W'(by) - DIFF_W'(ay);
        r_vx <= DIFF_W'(cx) - DIFF_W'(bx);
        r_vy <= DIFF_W'(cy) - DIFF_W'(by);
        r_s1_sel  <= i_cmd.turn_sel;
        r_s1_conv <= i_cmd.turn_conv;
        r_m1 <= r_ux * r_vy;
        r_m2 <= r_uy * r_vx;
        r_s2_sel  <= r_s1_sel;
        r_s2_conv <= r_s1_conv;
        if (r_s2_v && !r_s2_conv) begin
            r_ori[r_s2_sel] <= ori_now;
        end
    end

    function automatic logic in_box(input logic signed [COORD_BITS-1:0] ax_f, ay_f,
                                    mx_f, my_f, cx_f, cy_f);
        logic signed [COORD_BITS-1:0] lox, hix, loy, hiy;
        lox = (ax_f < cx_f) ? ax_f : cx_f;
        hix = (ax_f < cx_f) ? cx_f : ax_f;
        loy = (ay_f < cy_f) ? ay_f : cy_f;
        hiy = (ay_f < cy_f) ? cy_f : ay_f;
        return (mx_f >= lox) && (mx_f <= hix) && (my_f >= loy) && (my_f <= hiy);
    endfunction

    logic meet;
    always_comb begin
        meet = ((r_ori[0] != r_ori[1]) && (r_ori[2] != r_ori[3])) ||
               ((r_ori[0] == ORI_ZERO) &&
                in_box(r_px[0], r_py[0], r_px[2], r_py[2], r_px[1], r_py[1])) ||
               ((r_ori[1] == ORI_ZERO) &&
                in_box(r_px[0], r_py[0], r_px[3], r_py[3], r_px[1], r_py[1])) ||
               ((r_ori[2] == ORI_ZERO) &&
                in_box(r_px[2], r_py[2], r_px[0], r_py[0], r_px[3], r_py[3])) ||
               ((r_ori[3] == ORI_ZERO) &&
                in_box(r_px[2], r_py[2], r_px[1], r_py[1], r_px[3], r_py[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept   <= '0;
            r_raw    <= '0;
            r_ovf    <= 1'b0;
            r_n      <= '0;
            r_status <= ST_OK;
            r_simple <= 1'b0;
            r_pos    <= 1'b0;
            r_neg    <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.turn_en;
            r_s2_v <= r_s1_v;
            if (i_cmd.accept) begin
                r_first_x <= first_x_nx;
                r_first_y <= first_y_nx;
                r_last_x  <= last_x_nx;
                r_last_y  <= last_y_nx;
                if (i_last_vertex) begin
                    r_kept   <= '0;
                    r_raw    <= '0;
                    r_ovf    <= 1'b0;
                    r_n      <= n_fin;
                    r_status <= status_nx;
                    r_simple <= 1'b1;
                    r_pos    <= 1'b0;
                    r_neg    <= 1'b0;
                end else begin
                    r_kept <= kept_nx;
                    r_raw  <= raw_nx;
                    r_ovf  <= ovf_nx;
                end
            end
            if (i_cmd.eval && meet) begin
                r_simple <= 1'b0;
            end
            if (r_s2_v && r_s2_conv) begin
                if (ori_now == ORI_POS) r_pos <= 1'b1;
                if (ori_now == ORI_NEG) r_neg <= 1'b1;
            end
        end
    end

    assign o_sts.err    = (status_nx != ST_OK);
    assign o_sts.n      = r_n;
    assign o_sts.simple = r_simple;

    assign o_is_simple  = r_simple && (r_status == ST_OK);
    assign o_is_convex  = !(r_pos && r_neg) && (r_status == ST_OK);
    assign o_kept_count = KEPT_W'(r_n);
    assign o_status     = r_status;
endmodule
`default_nettype wire

// File: rtl/pscc_ctrl.sv
// controller: load handshake, edge-pair and turn loops, result handshake
// depends on pscc_pkg
`default_nettype none
module pscc_ctrl import pscc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_last_vertex,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [1:0] {S_LOAD, S_PICK, S_PAIR, S_CONV} t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_i, r_j, r_k;
    logic [CNT_W-1:0]  i1, j1, k1, k2;
    logic              accept;

    always_comb begin
        i1 = (r_i + CNT_W'(1) == i_sts.n) ? '0 : r_i + CNT_W'(1);
        j1 = (r_j + CNT_W'(1) == i_sts.n) ? '0 : r_j + CNT_W'(1);
        k1 = (r_k + CNT_W'(1) == i_sts.n) ? '0 : r_k + CNT_W'(1);
        k2 = (r_k + CNT_W'(2) >= i_sts.n) ? r_k + CNT_W'(2) - i_sts.n : r_k + CNT_W'(2);
    end

    assign o_stall = (r_state != S_LOAD) || r_out_valid;
    assign o_valid = r_out_valid;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        if (r_state == S_PAIR) begin
            case (r_step)
                4'd0:    o_cmd.rd_addr = r_i[IDX_W-1:0];
                4'd1:    o_cmd.rd_addr = i1[IDX_W-1:0];
                4'd2:    o_cmd.rd_addr = r_j[IDX_W-1:0];
                default: o_cmd.rd_addr = j1[IDX_W-1:0];
            endcase
            o_cmd.ld_en    = (r_step >= 4'd1) && (r_step <= 4'd4);
            o_cmd.ld_slot  = 2'(r_step - 4'd1);
            o_cmd.turn_en  = (r_step >= 4'd5) && (r_step <= 4'd8);
            o_cmd.turn_sel = 2'(r_step - 4'd5);
            o_cmd.eval     = (r_step == 4'd11);
        end else if (r_state == S_CONV) begin
            case (r_step)
                4'd0:    o_cmd.rd_addr = r_k[IDX_W-1:0];
                4'd1:    o_cmd.rd_addr = k1[IDX_W-1:0];
                default: o_cmd.rd_addr = k2[IDX_W-1:0];
            endcase
            o_cmd.ld_en     = (r_step >= 4'd1) && (r_step <= 4'd3);
            o_cmd.ld_slot   = 2'(r_step - 4'd1);
            o_cmd.turn_en   = (r_step == 4'd4);
            o_cmd.turn_conv = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (accept && i_last_vertex) begin
                        if (i_sts.err) begin
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_PICK;
                            r_i     <= '0;
                            r_j     <= CNT_W'(2);
                        end
                    end
                end
                S_PICK: begin
                    r_step <= '0;
                    if (!i_sts.simple || (r_i + CNT_W'(2) >= i_sts.n)) begin
                        r_state <= S_CONV;
                        r_k     <= '0;
                    end else if (r_j >= i_sts.n) begin
                        r_i <= r_i + CNT_W'(1);
                        r_j <= r_i + CNT_W'(3);
                    end else if ((r_i == '0) && (r_j + CNT_W'(1) == i_sts.n)) begin
                        // first and last edges share a vertex
                        r_j <= r_j + CNT_W'(1);
                    end else begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd11) begin
                        r_state <= S_PICK;
                        r_j     <= r_j + CNT_W'(1);
                    end
                end
                S_CONV: begin
                    if (r_step == 4'd7) begin
                        r_step <= '0;
                        r_k    <= r_k + CNT_W'(1);
                        if (r_k + CNT_W'(1) == i_sts.n) begin
                            r_state     <= S_LOAD;
                            r_out_valid <= 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/polygon_simple_convex_classifier.sv
// vertices load one per cycle while o_stall is low; on an error status the result follows the last vertex
// in the next cycle, else it comes after the controller has tested each edge pair (n*(n-3)/2 pairs, fewer
// once an intersection is found) and has then taken the turn sign at each vertex
// throughput: one polygon at a time; input stalls from the last vertex until the result is taken
// reset: synchronous active-low, clears counts, flags and handshake state; store is not cleared
`default_nettype none
module polygon_simple_convex_classifier import pscc_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                         i_last_vertex,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_is_simple,
    output logic                              o_is_convex,
    output logic [KEPT_W-1:0]                 o_kept_count,
    output logic [STATUS_W-1:0]               o_status
);
    t_cmd cmd;
    t_sts sts;

    pscc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last_vertex (i_last_vertex),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    pscc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_is_simple   (o_is_simple),
        .o_is_convex   (o_is_convex),
        .o_kept_count  (o_kept_count),
        .o_status      (o_status)
    );
endmodule
`default_nettype wire

// File: test/pscc_checker.sv
`timescale 1ns / 100ps
// checker for the polygon classifier: watches both channels, predicts each result word
// from the accepted vertices and compares it field by field; depends on pscc_pkg
`default_nettype none
module pscc_checker import pscc_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_stall_in,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                         i_last_vertex,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_stall_out,
    input  wire logic                         i_is_simple,
    input  wire logic                         i_is_convex,
    input  wire logic [KEPT_W-1:0]            i_kept_count,
    input  wire logic [STATUS_W-1:0]          i_status,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_results
);

    typedef struct packed {
        logic                simple;
        logic                convex;
        logic [KEPT_W-1:0]   kept;
        logic [STATUS_W-1:0] status;
    } t_verdict;

    t_verdict verdict_q[$];
    int       px[MAX_VERTICES];
    int       py[MAX_VERTICES];
    int       kept_n;
    int       read_n;
    logic     full_hit;

    function automatic longint turn_of(int a, int b, int c);
        longint ux, uy, wx, wy;
        ux = longint'(px[b]) - px[a];
        uy = longint'(py[b]) - py[a];
        wx = longint'(px[c]) - px[b];
        wy = longint'(py[c]) - py[b];
        return ux * wy - uy * wx;
    endfunction

    function automatic int side_of(int a, int b, int c);
        longint t;
        t = turn_of(a, b, c);
        if (t == 0) return 0;
        return (t > 0) ? 2 : 1;
    endfunction

    function automatic bit in_box(int a, int m, int c);
        int lox, hix, loy, hiy;
        lox = (px[a] < px[c]) ? px[a] : px[c];
        hix = (px[a] < px[c]) ? px[c] : px[a];
        loy = (py[a] < py[c]) ? py[a] : py[c];
        hiy = (py[a] < py[c]) ? py[c] : py[a];
        return px[m] >= lox && px[m] <= hix && py[m] >= loy && py[m] <= hiy;
    endfunction

    function automatic bit edges_cross(int p1, int q1, int p2, int q2);
        int o1, o2, o3, o4;
        o1 = side_of(p1, q1, p2);
        o2 = side_of(p1, q1, q2);
        o3 = side_of(p2, q2, p1);
        o4 = side_of(p2, q2, q1);
        if (o1 != o2 && o3 != o4) return 1;
        if (o1 == 0 && in_box(p1, p2, q1)) return 1;
        if (o2 == 0 && in_box(p1, q2, q1)) return 1;
        if (o3 == 0 && in_box(p2, p1, q2)) return 1;
        if (o4 == 0 && in_box(p2, q1, q2)) return 1;
        return 0;
    endfunction

    function automatic bit polygon_simple(int n);
        for (int i = 0; i < n; i++)
            for (int j = i + 2; j < n; j++) begin
                if (i == 0 && j == n - 1) continue;
                if (edges_cross(i, (i + 1) % n, j, (j + 1) % n)) return 0;
            end
        return 1;
    endfunction

    function automatic bit polygon_convex(int n);
        bit pos, neg;
        longint t;
        pos = 0;
        neg = 0;
        for (int i = 0; i < n; i++) begin
            t = turn_of(i, (i + 1) % n, (i + 2) % n);
            if (t > 0) pos = 1;
            if (t < 0) neg = 1;
        end
        return !(pos && neg);
    endfunction

    task automatic take_vertex(int x, int y, bit last);
        t_verdict v;
        if (read_n < 511) read_n++;
        if (kept_n == 0 || px[kept_n - 1] != x || py[kept_n - 1] != y) begin
            if (kept_n < MAX_VERTICES) begin
                px[kept_n] = x;
                py[kept_n] = y;
                kept_n++;
            end else begin
                full_hit = 1;
            end
        end
        if (!last) return;
        // closing vertex repeats the first one
        if (!full_hit && kept_n > 1 && px[0] == px[kept_n - 1] && py[0] == py[kept_n - 1])
            kept_n--;
        v = '0;
        v.kept = kept_n[KEPT_W-1:0];
        if (read_n < MIN_POLY)     v.status = ST_FEW_READ;
        else if (full_hit)         v.status = ST_OVERFLOW;
        else if (kept_n < MIN_POLY) v.status = ST_FEW_KEPT;
        else begin
            v.status = ST_OK;
            v.simple = polygon_simple(kept_n);
            v.convex = polygon_convex(kept_n);
        end
        verdict_q.insert(verdict_q.size(), v);
        kept_n = 0;
        read_n = 0;
        full_hit = 0;
    endtask

    task automatic compare_word();
        t_verdict e;
        if (verdict_q.size() == 0) begin
            $display("%0t: result word with nothing expected: simple=%0d convex=%0d kept=%0d st=%0d",
                     $time, i_is_simple, i_is_convex, i_kept_count, i_status);
            o_fail_count++;
            return;
        end
        e = verdict_q.pop_front();
        if (i_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, i_status);
            o_fail_count++;
        end
        if (i_kept_count !== e.kept) begin
            $display("%0t: kept_count expected %0d actual %0d", $time, e.kept, i_kept_count);
            o_fail_count++;
        end
        if (i_is_simple !== e.simple) begin
            $display("%0t: is_simple expected %0d actual %0d", $time, e.simple, i_is_simple);
            o_fail_count++;
        end
        if (i_is_convex !== e.convex) begin
            $display("%0t: is_convex expected %0d actual %0d", $time, e.convex, i_is_convex);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_results = 0;
        kept_n = 0;
        read_n = 0;
        full_hit = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_stall_out) begin
                compare_word();
                o_results++;
            end
            if (i_valid && !i_stall_in)
                take_vertex(int'(i_vertex_x), int'(i_vertex_y), i_last_vertex);
        end
        o_pending = verdict_q.size();
    end

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// top of the polygon classifier testbench: clock, reset, vertex stimulus and result stalls;
// depends on pscc_pkg, polygon_simple_convex_classifier and pscc_checker
`default_nettype none
module tb_top;
    import pscc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [COORD_BITS-1:0] i_vertex_x;
    logic signed [COORD_BITS-1:0] i_vertex_y;
    logic                    i_last_vertex;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_is_simple;
    logic                    o_is_convex;
    logic [KEPT_W-1:0]       o_kept_count;
    logic [STATUS_W-1:0]     o_status;

    int   fail_count, pending, results;
    logic in_fire_q, out_fire_q;
    bit   calm;
    bit   hold_req;
    int   vertex_total, polygon_total;
    int   cycles = 0;

    polygon_simple_convex_classifier DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_last_vertex(i_last_vertex),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_is_simple(o_is_simple), .o_is_convex(o_is_convex),
        .o_kept_count(o_kept_count), .o_status(o_status)
    );

    pscc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_last_vertex(i_last_vertex),
        .i_out_valid(o_valid), .i_stall_out(i_stall),
        .i_is_simple(o_is_simple), .i_is_convex(o_is_convex),
        .i_kept_count(o_kept_count), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_fire_q  <= i_rst_n && i_valid && !o_stall;
        out_fire_q <= i_rst_n && o_valid && !i_stall;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: short random stalls per word, plus a long hold-off on request
    initial begin
        int stall_left, long_left;
        stall_left = 0;
        long_left = 0;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                long_left = 400;
                hold_req = 0;
            end
            if (out_fire_q)
                stall_left = calm ? 0 : $urandom_range(0, 11);
            i_stall = (stall_left > 0) || (long_left > 0);
            if (stall_left > 0) stall_left--;
            if (long_left > 0) long_left--;
        end
    end

    task automatic send_vertex(int x, int y, bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1;
        i_vertex_x = x[COORD_BITS-1:0];
        i_vertex_y = y[COORD_BITS-1:0];
        i_last_vertex = last;
        do @(negedge i_clk); while (!in_fire_q);
        vertex_total++;
        if (last) polygon_total++;
    endtask

    task automatic send_shape(int xs[$], int ys[$]);
        for (int i = 0; i < xs.size(); i++)
            send_vertex(xs[i], ys[i], i == xs.size() - 1);
    endtask

    // random polygon; small coordinates make repeats, collinear and touching edges likely
    task automatic send_random_shape(int n, bit tight);
        int x, y, fx, fy, span;
        span = tight ? 6 : 32767;
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 9) == 0) begin
                // repeat of the previous vertex
            end else begin
                x = tight ? $urandom_range(0, 2 * span) - span : int'($signed(16'($urandom)));
                y = tight ? $urandom_range(0, 2 * span) - span : int'($signed(16'($urandom)));
            end
            if (i == 0) begin
                fx = x;
                fy = y;
            end
            send_vertex(x, y, (i == n - 1) && $urandom_range(0, 3) != 0);
        end
        // send the first vertex or a fresh one with last set; it closes the ring or stands alone
        if ($urandom_range(0, 1)) send_vertex(fx, fy, 1);
        else send_vertex(x + 1, y, 1);
    endtask

    task automatic send_convex_shape(int n);
        int cx, cy, r;
        cx = $urandom_range(0, 2000) - 1000;
        cy = $urandom_range(0, 2000) - 1000;
        r = $urandom_range(10, 20000);
        for (int i = 0; i < n; i++)
            send_vertex(cx + int'(r * $cos(6.2831853 * i / n)),
                        cy + int'(r * $sin(6.2831853 * i / n)), i == n - 1);
    endtask

    initial begin
        int n;
        i_rst_n = 0;
        i_valid = 0;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_last_vertex = 0;
        calm = 0;
        hold_req = 0;
        vertex_total = 0;
        polygon_total = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // directed shapes
        send_shape('{0, 10, 10, 0}, '{0, 0, 10, 10});
        send_shape('{0, 0, 5, 0, 0}, '{0, 0, 0, 5, 0});
        send_shape('{-32768, 32767, 32767}, '{-32768, -32768, 32767});
        send_shape('{0, 10, 10, 0}, '{0, 10, 0, 10});
        send_shape('{3, 4}, '{3, 4});
        send_shape('{-1}, '{-1});
        send_shape('{7, 7, 7}, '{-7, -7, -7});
        send_shape('{0, 1, 2}, '{0, 1, 2});

        // receiver holds off while vertices keep coming
        hold_req = 1;
        calm = 1;
        for (int k = 0; k < 4; k++) send_random_shape(4, 1);
        calm = 0;

        // store runs full: overflow, then exactly full
        for (int i = 0; i <= MAX_VERTICES; i++)
            send_vertex(i, i * i % 997, i == MAX_VERTICES);
        for (int i = 0; i < MAX_VERTICES; i++)
            send_vertex(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                        i == MAX_VERTICES - 1);

        // sender pauses until every result is back
        while (pending != 0) @(negedge i_clk);

        while (vertex_total < 640) begin
            calm = ($urandom_range(0, 7) == 0);
            n = $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: send_convex_shape(n + 2);
                1: send_random_shape(n, 0);
                default: send_random_shape(n, 1);
            endcase
        end
        calm = 0;
        i_valid = 0;
        i_last_vertex = 0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("sent %0d vertices in %0d polygons, %0d result words checked",
                 vertex_total, polygon_total, results);
        $display("covered repeats, closing vertices, short rings, overflow and a full store");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
